// ===== design/sswg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sswg_pkg;

  localparam int IDX_W       = 12;
  localparam int COORD_W     = 24;
  localparam int COUNT_W     = 13;
  localparam int STEP_W      = 23;
  localparam int PHASE_W     = 32;
  localparam int MODE_W      = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int WAVE_W      = 17;
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = 23;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int XSUM_W      = 36;

  localparam int MAX_POINTS_DEFAULT       = 4096;
  localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [WAVE_W-1:0] WAVE_ONE = 17'd65536;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINE     = 3'd0,
    MODE_SINE     = 3'd1,
    MODE_COSINE   = 3'd2,
    MODE_SQUARE   = 3'd3,
    MODE_TRIANGLE = 3'd4,
    MODE_PULSE    = 3'd5
  } shape_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHAPE_MODE   = 3'd0,
    REG_POINT_COUNT  = 3'd1,
    REG_X_STEP       = 3'd2,
    REG_ACTIVE_LIMIT = 3'd3,
    REG_PHASE_STEP   = 3'd4,
    REG_HALF_SWING   = 3'd5,
    REG_RAMP_STEP    = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_P,
    ST_MUL_POS,
    ST_ROM,
    ST_SCALE,
    ST_DONE
  } sswg_state_t;

  // Quarter-wave entry: round(sin(angle) * 65536), angle in Q2.30, integer Taylor series.
  function automatic logic [WAVE_W-1:0] quarter_wave_entry(input logic [63:0] angle);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] val;
    x2   = (angle * angle) >> 30;
    term = angle;
    sum  = angle;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    val  = (sum + 64'd8192) >> 14;
    if (val > 64'd65536) begin
      val = 64'd65536;
    end
    return val[WAVE_W-1:0];
  endfunction

  // Clamp to the signed 24-bit coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [XSUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 36'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -36'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/sswg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sswg_req_if;
  logic                                   valid;
  logic                                   ready;
  logic        [sswg_pkg::IDX_W-1:0]      point_index;
  logic signed [sswg_pkg::COORD_W-1:0]    base_x;
  logic signed [sswg_pkg::COORD_W-1:0]    base_y;

  modport source (output valid, output point_index, output base_x, output base_y,
                  input ready);
  modport sink   (input valid, input point_index, input base_x, input base_y,
                  output ready);
endinterface

interface sswg_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sswg_pkg::COORD_W-1:0]    point_x;
  logic signed [sswg_pkg::COORD_W-1:0]    point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

// ===== design/string_shape_waveform_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: IDLE, MUL_X, MUL_P, MUL_POS, ROM, SCALE, DONE; the result registers when
//   DONE finds the result slot free. One request at a time (ready only in IDLE); one
//   32x23 multiplier, one product a cycle, does x, phase, table index, then scaling.
// Reset: rst (synchronous) loads register defaults and clears the sequencer, result
//   valid and the stored previous y; the sine table is constant and needs no fill.

module string_shape_waveform_generator #(
  parameter int MAX_POINTS       = sswg_pkg::MAX_POINTS_DEFAULT,
  parameter int SINE_TABLE_DEPTH = sswg_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [sswg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [sswg_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  sswg_req_if.sink                                 req,
  sswg_rsp_if.source                               rsp
);

  localparam int TIDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int ROMA_W = $clog2(SINE_TABLE_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sswg_pkg::MODE_W-1:0]           shape_mode;
  logic [sswg_pkg::COUNT_W-1:0]          point_count;
  logic [sswg_pkg::STEP_W-1:0]           x_step;
  logic signed [sswg_pkg::COORD_W-1:0]   active_limit;
  logic [sswg_pkg::PHASE_W-1:0]          phase_step;
  logic [sswg_pkg::STEP_W-1:0]           half_swing;
  logic [sswg_pkg::STEP_W-1:0]           ramp_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode   <= sswg_pkg::MODE_W'(sswg_pkg::MODE_LINE);
      point_count  <= sswg_pkg::COUNT_W'(64);
      x_step       <= sswg_pkg::STEP_W'(256);
      active_limit <= '0;
      phase_step   <= '0;
      half_swing   <= '0;
      ramp_step    <= '0;
    end else if (cfg_wr_en) begin
      case (sswg_pkg::cfg_reg_t'(cfg_index))
        sswg_pkg::REG_SHAPE_MODE:   shape_mode <= cfg_wr_data[sswg_pkg::MODE_W-1:0];
        sswg_pkg::REG_POINT_COUNT: begin
          // Clamp counts above the supported maximum.
          if (32'(cfg_wr_data[sswg_pkg::COUNT_W-1:0]) > 32'(MAX_POINTS)) begin
            point_count <= sswg_pkg::COUNT_W'(MAX_POINTS);
          end else begin
            point_count <= cfg_wr_data[sswg_pkg::COUNT_W-1:0];
          end
        end
        sswg_pkg::REG_X_STEP:       x_step       <= cfg_wr_data[sswg_pkg::STEP_W-1:0];
        sswg_pkg::REG_ACTIVE_LIMIT: active_limit <= cfg_wr_data[sswg_pkg::COORD_W-1:0];
        sswg_pkg::REG_PHASE_STEP:   phase_step   <= cfg_wr_data[sswg_pkg::PHASE_W-1:0];
        sswg_pkg::REG_HALF_SWING:   half_swing   <= cfg_wr_data[sswg_pkg::STEP_W-1:0];
        sswg_pkg::REG_RAMP_STEP:    ramp_step    <= cfg_wr_data[sswg_pkg::STEP_W-1:0];
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Quarter-wave table, D+1 entries of Q1.16, built at elaboration. Read is
  // registered, one address per request.
  // ---------------------------------------------------------------------------
  logic [sswg_pkg::WAVE_W-1:0] qw_rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_qw
    localparam logic [63:0] ANGLE =
      sswg_pkg::HALF_PI_Q30 * 64'(k) / 64'(SINE_TABLE_DEPTH);
    assign qw_rom[k] = sswg_pkg::quarter_wave_entry(ANGLE);
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  sswg_pkg::sswg_state_t state, state_next;

  logic [sswg_pkg::IDX_W-1:0]           idx;
  logic signed [sswg_pkg::COORD_W-1:0]  bx;
  logic signed [sswg_pkg::COORD_W-1:0]  by;
  logic [sswg_pkg::XSUM_W-1:0]          x_sum;
  logic                                 active;
  logic [31:0]                          frac;
  logic [sswg_pkg::MUL_P_W-1:0]         mul_q;
  logic [sswg_pkg::WAVE_W-1:0]          rom_q;
  logic                                 wave_neg;   // wave value below zero
  logic                                 wave_pos;   // wave value above zero
  logic                                 scale_neg;  // sign of the scaled wave
  logic signed [sswg_pkg::COORD_W-1:0]  previous_y;
  logic                                 out_valid;
  logic signed [sswg_pkg::COORD_W-1:0]  out_x;
  logic signed [sswg_pkg::COORD_W-1:0]  out_y;

  // Shared multiplier operands, chosen by the sequencer step.
  logic [sswg_pkg::MUL_A_W-1:0] mul_a;
  logic [sswg_pkg::MUL_B_W-1:0] mul_b;

  // Combinational helpers
  logic                         in_take;
  logic                         out_free;
  logic [31:0]                  frac_w;
  logic [TIDX_W-1:0]            tidx_raw;
  logic [TIDX_W-1:0]            tidx;
  logic [ROMA_W-1:0]            rom_addr;
  logic [17:0]                  wave_mag;
  logic                         wave_zero;
  logic [25:0]                  scaled;
  logic signed [27:0]           scaled_s;
  logic signed [27:0]           by_e;
  logic signed [27:0]           y_full;
  logic                         square_last;

  assign in_take  = req.valid && req.ready;
  // Result slot is free when empty or being drained this cycle.
  assign out_free = !out_valid || rsp.ready;

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      sswg_pkg::ST_IDLE:    if (req.valid) state_next = sswg_pkg::ST_MUL_X;
      sswg_pkg::ST_MUL_X:   state_next = sswg_pkg::ST_MUL_P;
      sswg_pkg::ST_MUL_P:   state_next = sswg_pkg::ST_MUL_POS;
      sswg_pkg::ST_MUL_POS: state_next = sswg_pkg::ST_ROM;
      sswg_pkg::ST_ROM:     state_next = sswg_pkg::ST_SCALE;
      sswg_pkg::ST_SCALE:   state_next = sswg_pkg::ST_DONE;
      sswg_pkg::ST_DONE:    if (out_free) state_next = sswg_pkg::ST_IDLE;
      default:              state_next = sswg_pkg::ST_IDLE;
    endcase
  end

  // Output logic: handshake and multiplier operand selection
  always_comb begin
    req.ready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      sswg_pkg::ST_IDLE:    req.ready = 1'b1;
      sswg_pkg::ST_MUL_X: begin
        mul_a = sswg_pkg::MUL_A_W'(x_step);
        mul_b = sswg_pkg::MUL_B_W'(idx);
      end
      sswg_pkg::ST_MUL_P: begin
        mul_a = phase_step;
        mul_b = sswg_pkg::MUL_B_W'(idx);
      end
      sswg_pkg::ST_MUL_POS: begin
        mul_a = sswg_pkg::MUL_A_W'(frac_w[29:0]);
        mul_b = sswg_pkg::MUL_B_W'(SINE_TABLE_DEPTH);
      end
      sswg_pkg::ST_SCALE: begin
        mul_a = sswg_pkg::MUL_A_W'(wave_mag);
        mul_b = half_swing;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sswg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The one multiplier; product registered before any further use.
  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  // Cycle fraction from the phase product: Q0.24 for most shapes, Q0.25 (half
  // rate) for the pulse; cosine-based shapes add a quarter cycle.
  always_comb begin
    if (shape_mode == sswg_pkg::MODE_W'(sswg_pkg::MODE_PULSE)) begin
      frac_w = {mul_q[24:0], 7'b0};
    end else begin
      frac_w = {mul_q[23:0], 8'b0};
    end
    case (shape_mode)
      sswg_pkg::MODE_W'(sswg_pkg::MODE_COSINE),
      sswg_pkg::MODE_W'(sswg_pkg::MODE_TRIANGLE),
      sswg_pkg::MODE_W'(sswg_pkg::MODE_PULSE): frac_w = frac_w + 32'h4000_0000;
      default: ;
    endcase
  end

  // Table index: fraction within the quadrant times D, truncated. Odd
  // quadrants read the table mirrored.
  always_comb begin
    tidx_raw = mul_q[30 +: TIDX_W];
    if (32'(tidx_raw) > 32'(SINE_TABLE_DEPTH - 1)) begin
      tidx = TIDX_W'(SINE_TABLE_DEPTH - 1);
    end else begin
      tidx = tidx_raw;
    end
    if (frac[30]) begin
      rom_addr = ROMA_W'(SINE_TABLE_DEPTH) - ROMA_W'(tidx);
    end else begin
      rom_addr = ROMA_W'(tidx);
    end
  end

  // Magnitude to scale: |wave| for most shapes, 1 + cos for the pulse.
  always_comb begin
    wave_zero = (rom_q == '0);
    if (shape_mode == sswg_pkg::MODE_W'(sswg_pkg::MODE_PULSE)) begin
      if (frac[31]) begin
        wave_mag = 18'(sswg_pkg::WAVE_ONE) - 18'(rom_q);
      end else begin
        wave_mag = 18'(sswg_pkg::WAVE_ONE) + 18'(rom_q);
      end
    end else begin
      wave_mag = 18'(rom_q);
    end
  end

  // Final y: round the scaled wave half away from zero, then apply the shape.
  always_comb begin
    scaled      = 26'((42'(mul_q[40:0]) + 42'd32768) >> 16);
    scaled_s    = scale_neg ? -$signed(28'(scaled)) : $signed(28'(scaled));
    by_e        = 28'(by);
    y_full      = by_e;
    square_last = (point_count != '0) &&
                  ((point_count - sswg_pkg::COUNT_W'(1)) == sswg_pkg::COUNT_W'(idx));
    if (active) begin
      case (shape_mode)
        sswg_pkg::MODE_W'(sswg_pkg::MODE_SINE):
          if (idx != '0) y_full = by_e - scaled_s;
        sswg_pkg::MODE_W'(sswg_pkg::MODE_COSINE):
          y_full = by_e - scaled_s;
        sswg_pkg::MODE_W'(sswg_pkg::MODE_SQUARE):
          if (idx != '0) begin
            y_full = wave_neg ? by_e - 28'(half_swing) : by_e + 28'(half_swing);
          end
        sswg_pkg::MODE_W'(sswg_pkg::MODE_TRIANGLE):
          if (idx != '0) begin
            y_full = wave_pos ? 28'(previous_y) + 28'(ramp_step)
                              : 28'(previous_y) - 28'(ramp_step);
          end
        sswg_pkg::MODE_W'(sswg_pkg::MODE_PULSE):
          y_full = by_e - scaled_s;
        default: ;  // line and unused modes keep the base
      endcase
    end
    // Square pins its last point to the base, active or not.
    if (shape_mode == sswg_pkg::MODE_W'(sswg_pkg::MODE_SQUARE) && square_last) begin
      y_full = by_e;
    end
  end

  // Datapath registers, advanced one step per sequencer state.
  always_ff @(posedge clk) begin
    if (in_take) begin
      idx <= req.point_index;
      bx  <= req.base_x;
      by  <= req.base_y;
    end
    if (state == sswg_pkg::ST_MUL_P) begin
      // Exact x, before saturation, for the active-region test.
      x_sum <= {{(sswg_pkg::XSUM_W - sswg_pkg::COORD_W){bx[sswg_pkg::COORD_W-1]}}, bx}
             + {1'b0, mul_q[34:0]};
    end
    if (state == sswg_pkg::ST_MUL_POS) begin
      frac   <= frac_w;
      active <= $signed(x_sum) <
                $signed({{(sswg_pkg::XSUM_W - sswg_pkg::COORD_W){active_limit[
                  sswg_pkg::COORD_W-1]}}, active_limit});
    end
    if (state == sswg_pkg::ST_ROM) begin
      rom_q <= qw_rom[rom_addr];
    end
    if (state == sswg_pkg::ST_SCALE) begin
      wave_neg  <= frac[31] && !wave_zero;
      wave_pos  <= !frac[31] && !wave_zero;
      scale_neg <= frac[31] &&
                   (shape_mode != sswg_pkg::MODE_W'(sswg_pkg::MODE_PULSE));
    end
  end

  // Result register and stored previous y.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      previous_y <= '0;
    end else begin
      if (state == sswg_pkg::ST_DONE && out_free) begin
        out_valid  <= 1'b1;
        previous_y <= sswg_pkg::sat_coord(36'(y_full));
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sswg_pkg::ST_DONE && out_free) begin
      out_x <= sswg_pkg::sat_coord($signed(x_sum));
      out_y <= sswg_pkg::sat_coord(36'(y_full));
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.point_x = out_x;
  assign rsp.point_y = out_y;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !req.ready)
    else $error("request accepted while the sequencer was busy");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == sswg_pkg::ST_DONE)
    else $error("result raised outside the final step");

  a_prev_tracks_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> previous_y == rsp.point_y)
    else $error("stored previous y differs from the pending result");

  a_rom_addr_range: assert property (@(posedge clk) disable iff (rst)
    state == sswg_pkg::ST_ROM |-> 32'(rom_addr) <= 32'(SINE_TABLE_DEPTH))
    else $error("sine table address out of range");

endmodule

`default_nettype wire
